// File: src/srt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the scan result table.
// No dependencies.
package srt_pkg;

  localparam int unsigned TABLE_DEPTH   = 128;
  localparam int unsigned FULL_LIMIT    = 100;
  localparam int unsigned PRUNE_DIVISOR = 4;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_BATCH   = 2'd1,
    CMD_PRUNE   = 2'd2,
    CMD_READ    = 2'd3
  } srt_cmd_e;

  typedef enum logic [1:0] {
    STAT_UPDATED  = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_IGNORED  = 2'd2,
    STAT_DONE     = 2'd3
  } srt_status_e;

  typedef enum logic [1:0] {
    CFG_LOCATE_ENABLE = 2'd0,
    CFG_LOCATE_TARGET = 2'd1,
    CFG_SPARE2        = 2'd2,
    CFG_SPARE3        = 2'd3
  } srt_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_OBS_RD, S_OBS_CMP, S_RD_WAIT, S_SRT_NEXT, S_SRT_KEY,
    S_SRT_JCHK, S_SRT_JCMP, S_MOV_RD, S_MOV_WR, S_DONE
  } srt_state_e;

  typedef struct packed {
    logic [47:0]        bssid;
    logic signed [7:0]  rssi;
    logic [3:0]         channel;
    logic [3:0]         auth;
    logic [31:0]        last_seen;
  } srt_entry_t;

  localparam int unsigned ENTRY_W = $bits(srt_entry_t);

  typedef struct packed {
    logic [1:0]         command;
    logic [47:0]        bssid;
    logic signed [7:0]  rssi;
    logic [3:0]         channel;
    logic [3:0]         auth_mode;
    logic               ssid_present;
    logic [31:0]        now_ms;
    logic [6:0]         read_index;
  } srt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               entry_valid;
    logic [47:0]        entry_bssid;
    logic signed [7:0]  entry_rssi;
    logic [3:0]         entry_channel;
    logic [3:0]         entry_auth;
    logic [31:0]        entry_last_seen;
    logic [7:0]         entry_count;
  } srt_out_t;

  typedef struct packed {
    logic bssid_eq;
    logic ahead;
  } srt_cmp_t;

endpackage

// File: src/srt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/srt_cmp.sv
`timescale 1ns / 1ps
// Shared entry comparator: BSSID match and sort ordering (RSSI or age).
// Depends on srt_pkg.
module srt_cmp (
  input  srt_pkg::srt_entry_t a_i,
  input  srt_pkg::srt_entry_t b_i,
  input  logic                by_age_i,
  output srt_pkg::srt_cmp_t   res_o
);

  always_comb begin
    res_o.bssid_eq = (a_i.bssid == b_i.bssid);
    if (!by_age_i) begin
      res_o.ahead = (a_i.rssi > b_i.rssi);
    end else if (a_i.last_seen != b_i.last_seen) begin
      res_o.ahead = (a_i.last_seen < b_i.last_seen);
    end else begin
      res_o.ahead = (a_i.rssi < b_i.rssi);
    end
  end

endmodule

// File: src/scan_result_table_unit.sv
`timescale 1ns / 1ps
// Top level of the scan result table: sequencer around one RAM and one comparator.
// Depends on srt_pkg, srt_ram, srt_cmp.
//
// Input beats (in_valid_i/in_ready_o) carry one command; each gives exactly one
// output beat (out_valid_o/out_ready_i). The block takes one command at a time.
// Work is paced by the single RAM read port (one entry per step):
//   read: fetches one entry; observe: scans the entries for the BSSID;
//   batch sort / prune: insertion sort (by RSSI, or by age for prune),
//   prune adds a move down that drops the oldest capacity/4 entries.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
// Reset empties the table (count zero, locate mode off); entry contents are
// not cleared, they are only read once written.
// When the receiver stalls, the result holds in the output register; a new
// command is still accepted and runs, and its result waits until the
// previous beat is taken.
module scan_result_table_unit #(
  parameter int unsigned TABLE_DEPTH = srt_pkg::TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [47:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  srt_pkg::srt_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srt_pkg::srt_out_t out_data_o
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CAP = (srt_pkg::FULL_LIMIT < TABLE_DEPTH) ?
                                srt_pkg::FULL_LIMIT : TABLE_DEPTH;
  localparam int unsigned DROP = CAP / srt_pkg::PRUNE_DIVISOR;

  srt_pkg::srt_state_e state_q, state_d;
  srt_pkg::srt_in_t    cmd_q;
  srt_pkg::srt_entry_t key_q, key_d;
  srt_pkg::srt_out_t   res_q, res_d;
  logic [CW-1:0]       count_q, count_d, i_q, i_d, j_q, j_d;
  logic                loc_en_q;
  logic [47:0]         loc_tgt_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  srt_pkg::srt_entry_t ram_wdata, ram_rdata;
  logic [srt_pkg::ENTRY_W-1:0] ram_rdata_raw;
  srt_pkg::srt_entry_t cmp_a, cmp_b;
  srt_pkg::srt_cmp_t   cmp_res;
  srt_pkg::srt_entry_t new_ent;

  logic        locating, obs_drop, by_age, out_free;
  logic [CW-1:0] limit;
  logic [15:0] idx_w;

  srt_ram #(.WIDTH(srt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );
  assign ram_rdata = srt_pkg::srt_entry_t'(ram_rdata_raw);

  srt_cmp u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .by_age_i(by_age),
    .res_o   (cmp_res)
  );

  assign locating = loc_en_q && (loc_tgt_q != 48'd0);
  assign limit    = locating ? CW'(TABLE_DEPTH) : CW'(CAP);
  assign obs_drop = !cmd_q.ssid_present || (locating && cmd_q.bssid != loc_tgt_q) ||
                    (!locating && count_q >= CW'(CAP));
  assign by_age   = (cmd_q.command == srt_pkg::CMD_PRUNE);
  assign idx_w    = 16'(cmd_q.read_index);
  assign out_free = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == srt_pkg::S_IDLE);

  assign new_ent.bssid     = cmd_q.bssid;
  assign new_ent.rssi      = cmd_q.rssi;
  assign new_ent.channel   = cmd_q.channel;
  assign new_ent.auth      = cmd_q.auth_mode;
  assign new_ent.last_seen = cmd_q.now_ms;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srt_pkg::S_IDLE: if (in_valid_i) state_d = srt_pkg::S_DISPATCH;
      srt_pkg::S_DISPATCH: begin
        unique case (cmd_q.command)
          srt_pkg::CMD_OBSERVE: state_d = obs_drop ? srt_pkg::S_DONE : srt_pkg::S_OBS_RD;
          srt_pkg::CMD_BATCH:   state_d = loc_en_q ? srt_pkg::S_DONE : srt_pkg::S_SRT_NEXT;
          srt_pkg::CMD_PRUNE:   state_d = (count_q >= CW'(CAP) && DROP > 0) ?
                                          srt_pkg::S_SRT_NEXT : srt_pkg::S_DONE;
          default:              state_d = (idx_w < 16'(count_q)) ?
                                          srt_pkg::S_RD_WAIT : srt_pkg::S_DONE;
        endcase
      end
      srt_pkg::S_OBS_RD:  state_d = (i_q == count_q) ? srt_pkg::S_DONE : srt_pkg::S_OBS_CMP;
      srt_pkg::S_OBS_CMP: state_d = cmp_res.bssid_eq ? srt_pkg::S_DONE : srt_pkg::S_OBS_RD;
      srt_pkg::S_RD_WAIT: state_d = srt_pkg::S_DONE;
      srt_pkg::S_SRT_NEXT: begin
        if (i_q < count_q) state_d = srt_pkg::S_SRT_KEY;
        else if (by_age)   state_d = srt_pkg::S_MOV_RD;
        else               state_d = srt_pkg::S_DONE;
      end
      srt_pkg::S_SRT_KEY:  state_d = srt_pkg::S_SRT_JCHK;
      srt_pkg::S_SRT_JCHK: state_d = (j_q == '0) ? srt_pkg::S_SRT_NEXT : srt_pkg::S_SRT_JCMP;
      srt_pkg::S_SRT_JCMP: state_d = cmp_res.ahead ? srt_pkg::S_SRT_JCHK :
                                     srt_pkg::S_SRT_NEXT;
      srt_pkg::S_MOV_RD:   state_d = (i_q == count_q - CW'(DROP)) ? srt_pkg::S_DONE :
                                     srt_pkg::S_MOV_WR;
      srt_pkg::S_MOV_WR:   state_d = srt_pkg::S_MOV_RD;
      srt_pkg::S_DONE:     if (out_free) state_d = srt_pkg::S_IDLE;
      default:             state_d = srt_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    key_d     = key_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = key_q;
    ram_raddr = i_q[AW-1:0];
    cmp_a     = new_ent;
    cmp_b     = ram_rdata;
    unique case (state_q)
      srt_pkg::S_IDLE: begin
        res_d = '0;
        res_d.status = srt_pkg::STAT_DONE;
      end
      srt_pkg::S_DISPATCH: begin
        unique case (cmd_q.command)
          srt_pkg::CMD_OBSERVE: begin
            i_d = '0;
            if (obs_drop) res_d.status = srt_pkg::STAT_IGNORED;
          end
          srt_pkg::CMD_BATCH, srt_pkg::CMD_PRUNE: i_d = CW'(1);
          default: ram_raddr = idx_w[AW-1:0];
        endcase
      end
      srt_pkg::S_OBS_RD: begin
        if (i_q == count_q) begin
          if (count_q < limit) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = new_ent;
            count_d   = count_q + CW'(1);
            res_d.status = srt_pkg::STAT_INSERTED;
          end else begin
            res_d.status = srt_pkg::STAT_IGNORED;
          end
        end
      end
      srt_pkg::S_OBS_CMP: begin
        if (cmp_res.bssid_eq) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_wdata.rssi      = cmd_q.rssi;
          ram_wdata.last_seen = cmd_q.now_ms;
          res_d.status = srt_pkg::STAT_UPDATED;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      srt_pkg::S_RD_WAIT: begin
        res_d.entry_valid     = 1'b1;
        res_d.entry_bssid     = ram_rdata.bssid;
        res_d.entry_rssi      = ram_rdata.rssi;
        res_d.entry_channel   = ram_rdata.channel;
        res_d.entry_auth      = ram_rdata.auth;
        res_d.entry_last_seen = ram_rdata.last_seen;
      end
      srt_pkg::S_SRT_NEXT: if (i_q >= count_q) i_d = '0;
      srt_pkg::S_SRT_KEY: begin
        key_d = ram_rdata;
        j_d   = i_q;
      end
      srt_pkg::S_SRT_JCHK: begin
        ram_raddr = j_q[AW-1:0] - AW'(1);
        if (j_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = key_q;
          i_d       = i_q + CW'(1);
        end
      end
      srt_pkg::S_SRT_JCMP: begin
        cmp_a     = key_q;
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        if (cmp_res.ahead) begin
          ram_wdata = ram_rdata;
          j_d       = j_q - CW'(1);
        end else begin
          ram_wdata = key_q;
          i_d       = i_q + CW'(1);
        end
      end
      srt_pkg::S_MOV_RD: begin
        ram_raddr = i_q[AW-1:0] + AW'(DROP);
        if (i_q == count_q - CW'(DROP)) count_d = count_q - CW'(DROP);
      end
      srt_pkg::S_MOV_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        i_d       = i_q + CW'(1);
      end
      default: res_d.entry_count = 8'(count_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srt_pkg::S_IDLE;
      count_q     <= '0;
      loc_en_q    <= 1'b0;
      loc_tgt_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i && cfg_idx_i == srt_pkg::CFG_LOCATE_ENABLE) loc_en_q <= cfg_wdata_i[0];
      if (cfg_we_i && cfg_idx_i == srt_pkg::CFG_LOCATE_TARGET) loc_tgt_q <= cfg_wdata_i;
      if (state_q == srt_pkg::S_DONE && out_free) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_data_i;
    i_q   <= i_d;
    j_q   <= j_d;
    key_q <= key_d;
    res_q <= res_d;
    if (state_q == srt_pkg::S_DONE && out_free) begin
      out_data_o <= res_d;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready while busy");
  a_valid_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.entry_valid) |-> (out_data_o.status == srt_pkg::STAT_DONE))
    else $error("entry valid on observe result");
`endif

endmodule
